@@ src/pdoq_pkg.sv @@
package pdoq_pkg;

    // queue geometry
    localparam int QUEUE_DEPTH = 8;
    localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    // field widths
    localparam int TAG_W    = 16;
    localparam int MS_W     = 16;
    localparam int TCNT_W   = 4;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 1;

    // reset values of the configuration registers
    localparam logic [MS_W-1:0]   ACK_TIMEOUT_RST = MS_W'(120);
    localparam logic [TCNT_W-1:0] RETRY_LIMIT_RST = TCNT_W'(2);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ACK_TIMEOUT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_RETRY_LIMIT = 1'b1;

    // request kinds
    typedef enum logic [1:0] {
        FN_ENQUEUE = 2'd0,
        FN_ACK     = 2'd1,
        FN_SENT    = 2'd2,
        FN_TICK    = 2'd3
    } t_func;

    // result codes
    typedef enum logic [3:0] {
        ST_APPENDED      = 4'd0,
        ST_COALESCED     = 4'd1,
        ST_EVICT_APPEND  = 4'd2,
        ST_DROPPED       = 4'd3,
        ST_ACK_POPPED    = 4'd4,
        ST_IGNORED       = 4'd5,
        ST_MARKED_SENT   = 4'd6,
        ST_TIMEOUT_RETRY = 4'd7,
        ST_TIMEOUT_DROP  = 4'd8,
        ST_TICK          = 4'd9
    } t_status;

    // one queue entry
    typedef struct packed {
        logic [TAG_W-1:0] tag;
        logic             mouse;
        logic             crit;
    } t_entry;

    // per-cell control
    typedef struct packed {
        logic load;      // take the newcomer
        logic load_tag;  // replace the tag only
        logic shift;     // take the right neighbor's entry
    } t_cell_ctl;

    // victim search result
    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] idx;
    } t_victim;

endpackage

@@ src/pdoq_cell.sv @@
module pdoq_cell
    import pdoq_pkg::*;
(
    input  logic             i_clk,
    input  t_cell_ctl        i_ctl,
    input  t_entry           i_right,
    input  t_entry           i_new,
    output t_entry           o_entry,
    output logic [TAG_W-1:0] o_next_tag
);

    t_entry r_entry;
    t_entry n_entry;

    // load beats tag replace beats shift
    always_comb begin
        n_entry = r_entry;
        if (i_ctl.load) begin
            n_entry = i_new;
        end else if (i_ctl.load_tag) begin
            n_entry.tag = i_new.tag;
        end else if (i_ctl.shift) begin
            n_entry = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry    = r_entry;
    assign o_next_tag = n_entry.tag;

endmodule

@@ src/pdoq_victim.sv @@
module pdoq_victim
    import pdoq_pkg::*;
(
    input  logic [CNT_W-1:0]       i_occ,
    input  logic                   i_locked,
    input  logic [QUEUE_DEPTH-1:0] i_mouse,
    input  logic [QUEUE_DEPTH-1:0] i_crit,
    input  logic                   i_crit_new,
    output t_victim                o_victim
);

    logic [QUEUE_DEPTH-1:0] w_elig;
    logic                   w_head_locked;
    logic                   w_mouse_hit;
    logic [IDX_W-1:0]       w_mouse_idx;
    logic                   w_nc_hit;
    logic [IDX_W-1:0]       w_nc_idx;
    logic                   w_start_ok;

    assign w_head_locked = i_locked && (i_occ != '0);

    // occupied positions other than a locked head
    always_comb begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            w_elig[i] = (CNT_W'(i) < i_occ) && !(w_head_locked && (i == 0));
        end
    end

    // oldest non-critical mouse entry
    always_comb begin
        w_mouse_hit = 1'b0;
        w_mouse_idx = '0;
        for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
            if (w_elig[i] && i_mouse[i] && !i_crit[i]) begin
                w_mouse_hit = 1'b1;
                w_mouse_idx = IDX_W'(i);
            end
        end
    end

    // newest non-critical entry
    always_comb begin
        w_nc_hit = 1'b0;
        w_nc_idx = '0;
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            if (w_elig[i] && !i_crit[i]) begin
                w_nc_hit = 1'b1;
                w_nc_idx = IDX_W'(i);
            end
        end
    end

    // first unlocked position exists
    assign w_start_ok = w_head_locked ? (i_occ > CNT_W'(1)) : (i_occ != '0);

    always_comb begin
        o_victim = '0;
        if (w_mouse_hit) begin
            o_victim.found = 1'b1;
            o_victim.idx   = w_mouse_idx;
        end else if (w_nc_hit) begin
            o_victim.found = 1'b1;
            o_victim.idx   = w_nc_idx;
        end else if (!w_head_locked && (i_occ != '0)) begin
            o_victim.found = 1'b1;
            o_victim.idx   = '0;
        end else if (i_crit_new && w_start_ok) begin
            o_victim.found = 1'b1;
            o_victim.idx   = w_head_locked ? IDX_W'(1) : '0;
        end
    end

endmodule

@@ src/priority_drop_outbox_queue.sv @@
// priority_drop_outbox_queue
// ordered outbox of message tags held in a row of shifting cells.
// requests enter on the s_axis channel: tuser carries the kind (enqueue, ack,
// sent, one millisecond tick), tdata the tag and its mouse, coalesce and
// critical flags. every request gives exactly one result on m_axis: tuser
// carries the status code, tdata the evicted entry and the queue front.
// a request's result appears in the output register in the cycle after the
// request is taken, and one request is taken per cycle while the receiver
// takes the results; the victim search over all cells and the cell shift
// finish within the cycle in which the request is taken.
// when the receiver stalls the result holds in the output register and
// s_axis_tready stays low until it is taken.
// the configuration port writes the ack timeout (index 0) and the retry
// limit (index 1); write only while no request is in progress.
// synchronous reset empties the queue, clears the in-flight state and the
// timeout counters and loads the register defaults (120 ms, 2 retries);
// no clearing pass is needed.
module priority_drop_outbox_queue
    import pdoq_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    // msg_tag[15:0], is_mouse[16], may_coalesce[17], is_critical[18], zero[23:19]
    input  logic [23:0]          i_s_axis_tdata,
    // func[1:0]
    input  logic [1:0]           i_s_axis_tuser,
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    // evicted_valid[0], evicted_tag[16:1], front_valid[17], front_tag[33:18],
    // front_in_flight[34], entry_count[38:35], zero[39]
    output logic [39:0]          o_m_axis_tdata,
    // status[3:0]
    output logic [3:0]           o_m_axis_tuser,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    // control state
    logic [CNT_W-1:0]  r_occ,        n_occ;
    logic              r_in_flight,  n_in_flight;
    logic [TCNT_W-1:0] r_tcount,     n_tcount;
    logic [MS_W-1:0]   r_since,      n_since;
    logic [MS_W-1:0]   r_ack_timeout;
    logic [TCNT_W-1:0] r_retry_limit;

    // output register
    logic              r_out_valid;
    t_status           r_status,     n_status;
    logic              r_ev_valid,   n_ev_valid;
    logic [TAG_W-1:0]  r_ev_tag,     n_ev_tag;
    logic              r_front_valid;
    logic [TAG_W-1:0]  r_front_tag;
    logic              r_front_fl;
    logic [CNT_W-1:0]  r_count;

    // request fields
    logic    w_accept;
    t_func   w_func;
    t_entry  w_new;
    logic    w_coal_req;
    logic    w_crit_new;

    // cell row
    t_entry                 w_cells   [QUEUE_DEPTH];
    logic [TAG_W-1:0]       w_ntags   [QUEUE_DEPTH];
    t_cell_ctl              w_ctl     [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] w_mouse_v;
    logic [QUEUE_DEPTH-1:0] w_crit_v;
    t_victim                w_victim;

    // row operations chosen for this request
    logic             w_do_remove;
    logic [IDX_W-1:0] w_rem_idx;
    logic             w_do_append;
    logic [IDX_W-1:0] w_app_idx;
    logic             w_do_coal;
    logic [IDX_W-1:0] w_tail_idx;
    logic [TCNT_W-1:0] w_tcount_inc;

    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;

    assign w_func     = t_func'(i_s_axis_tuser);
    assign w_new.tag  = i_s_axis_tdata[15:0];
    assign w_new.mouse = i_s_axis_tdata[16];
    assign w_new.crit = i_s_axis_tdata[18];
    assign w_coal_req = i_s_axis_tdata[16] && i_s_axis_tdata[17];
    assign w_crit_new = i_s_axis_tdata[18];

    assign w_tail_idx   = IDX_W'(r_occ - CNT_W'(1));
    assign w_tcount_inc = r_tcount + TCNT_W'(1);

    // flag vectors for the victim search
    always_comb begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            w_mouse_v[i] = w_cells[i].mouse;
            w_crit_v[i]  = w_cells[i].crit;
        end
    end

    pdoq_victim u_victim (
        .i_occ      (r_occ),
        .i_locked   (r_in_flight),
        .i_mouse    (w_mouse_v),
        .i_crit     (w_crit_v),
        .i_crit_new (w_crit_new),
        .o_victim   (w_victim)
    );

    // request decode and next control state
    always_comb begin
        n_occ       = r_occ;
        n_in_flight = r_in_flight;
        n_tcount    = r_tcount;
        n_since     = r_since;
        n_status    = ST_IGNORED;
        n_ev_valid  = 1'b0;
        n_ev_tag    = '0;
        w_do_remove = 1'b0;
        w_rem_idx   = '0;
        w_do_append = 1'b0;
        w_app_idx   = '0;
        w_do_coal   = 1'b0;
        unique case (w_func)
            FN_ENQUEUE: begin
                if (w_coal_req && (r_occ != '0) && w_cells[w_tail_idx].mouse) begin
                    w_do_coal = 1'b1;
                    n_status  = ST_COALESCED;
                end else if (r_occ >= CNT_W'(QUEUE_DEPTH)) begin
                    if (w_victim.found) begin
                        w_do_remove = 1'b1;
                        w_rem_idx   = w_victim.idx;
                        w_do_append = 1'b1;
                        w_app_idx   = IDX_W'(QUEUE_DEPTH - 1);
                        n_ev_valid  = 1'b1;
                        n_ev_tag    = w_cells[w_victim.idx].tag;
                        n_status    = ST_EVICT_APPEND;
                    end else begin
                        n_status = ST_DROPPED;
                    end
                end else begin
                    w_do_append = 1'b1;
                    w_app_idx   = IDX_W'(r_occ);
                    n_occ       = r_occ + CNT_W'(1);
                    n_status    = ST_APPENDED;
                end
            end
            FN_ACK: begin
                if (r_in_flight) begin
                    if (r_occ != '0) begin
                        w_do_remove = 1'b1;
                        n_occ       = r_occ - CNT_W'(1);
                    end
                    n_in_flight = 1'b0;
                    n_tcount    = '0;
                    n_status    = ST_ACK_POPPED;
                end
            end
            FN_SENT: begin
                if ((r_occ != '0) && !r_in_flight) begin
                    n_in_flight = 1'b1;
                    n_since     = '0;
                    n_status    = ST_MARKED_SENT;
                end
            end
            FN_TICK: begin
                n_status = ST_TICK;
                if (r_in_flight) begin
                    if (r_since >= r_ack_timeout) begin
                        n_in_flight = 1'b0;
                        if (w_tcount_inc >= r_retry_limit) begin
                            if (r_occ != '0) begin
                                w_do_remove = 1'b1;
                                n_occ       = r_occ - CNT_W'(1);
                                n_ev_valid  = 1'b1;
                                n_ev_tag    = w_cells[0].tag;
                            end
                            n_tcount = '0;
                            n_status = ST_TIMEOUT_DROP;
                        end else begin
                            n_tcount = w_tcount_inc;
                            n_status = ST_TIMEOUT_RETRY;
                        end
                    end else if (r_since != {MS_W{1'b1}}) begin
                        n_since = r_since + MS_W'(1);
                    end
                end
            end
            default: begin
                n_status = ST_IGNORED;
            end
        endcase
    end

    // per-cell control from the chosen row operation
    always_comb begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            w_ctl[i].load     = w_accept && w_do_append && (IDX_W'(i) == w_app_idx);
            w_ctl[i].load_tag = w_accept && w_do_coal && (IDX_W'(i) == w_tail_idx);
            w_ctl[i].shift    = w_accept && w_do_remove && (IDX_W'(i) >= w_rem_idx);
        end
    end

    // row of cells, each takes from its right neighbor on a removal
    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        if (g < QUEUE_DEPTH - 1) begin : g_mid
            pdoq_cell u_cell (
                .i_clk      (i_clk),
                .i_ctl      (w_ctl[g]),
                .i_right    (w_cells[g+1]),
                .i_new      (w_new),
                .o_entry    (w_cells[g]),
                .o_next_tag (w_ntags[g])
            );
        end else begin : g_last
            pdoq_cell u_cell (
                .i_clk      (i_clk),
                .i_ctl      (w_ctl[g]),
                .i_right    (w_new),
                .i_new      (w_new),
                .o_entry    (w_cells[g]),
                .o_next_tag (w_ntags[g])
            );
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ack_timeout <= ACK_TIMEOUT_RST;
            r_retry_limit <= RETRY_LIMIT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ACK_TIMEOUT: r_ack_timeout <= i_cfg_data;
                CFG_RETRY_LIMIT: r_retry_limit <= i_cfg_data[TCNT_W-1:0];
                default: begin
                    r_ack_timeout <= r_ack_timeout;
                end
            endcase
        end
    end

    // queue control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ       <= '0;
            r_in_flight <= 1'b0;
            r_tcount    <= '0;
            r_since     <= '0;
        end else if (w_accept) begin
            r_occ       <= n_occ;
            r_in_flight <= n_in_flight;
            r_tcount    <= n_tcount;
            r_since     <= n_since;
        end
    end

    // output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status      <= n_status;
            r_ev_valid    <= n_ev_valid;
            r_ev_tag      <= n_ev_tag;
            r_front_valid <= (n_occ != '0);
            r_front_tag   <= (n_occ != '0) ? w_ntags[0] : '0;
            r_front_fl    <= n_in_flight;
            r_count       <= n_occ;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_status;
    assign o_m_axis_tdata  = {1'b0, 4'(r_count), r_front_fl, r_front_tag, r_front_valid,
                              r_ev_tag, r_ev_valid};

    // occupancy never passes the queue depth
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= CNT_W'(QUEUE_DEPTH))
        else $error("occupancy beyond queue depth");

    // an in-flight head implies a non-empty queue
    a_flight_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_flight |-> (r_occ != '0))
        else $error("in flight with empty queue");

    // an ack on an in-flight head pops it
    a_ack_pops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (w_func == FN_ACK) && r_in_flight) |=>
            ((o_m_axis_tuser == ST_ACK_POPPED) && !r_in_flight))
        else $error("ack on in-flight head not popped");

endmodule

@@ sim/outbox_checker.sv @@
module outbox_checker
    import pdoq_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_axis_tvalid,
    input  logic                 i_s_axis_tready,
    // msg_tag[15:0], is_mouse[16], may_coalesce[17], is_critical[18], zero[23:19]
    input  logic [23:0]          i_s_axis_tdata,
    // func[1:0]
    input  logic [1:0]           i_s_axis_tuser,
    input  logic                 i_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    // evicted_valid[0], evicted_tag[16:1], front_valid[17], front_tag[33:18],
    // front_in_flight[34], entry_count[38:35], zero[39]
    input  logic [39:0]          i_m_axis_tdata,
    // status[3:0]
    input  logic [3:0]           i_m_axis_tuser,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    output int                   o_fail_count,
    output int                   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // one result as seen on the master side
    typedef struct packed {
        t_status          status;
        logic             ev_valid;
        logic [TAG_W-1:0] ev_tag;
        logic             front_valid;
        logic [TAG_W-1:0] front_tag;
        logic             front_in_flight;
        logic [CNT_W-1:0] count;
    } t_outbox_result;

    // shadow copy of the outbox
    logic [TAG_W-1:0]  box_tag   [QUEUE_DEPTH];
    logic              box_mouse [QUEUE_DEPTH];
    logic              box_crit  [QUEUE_DEPTH];
    int                box_count;
    logic              head_in_flight;
    logic [TCNT_W-1:0] timeouts_seen;
    logic [MS_W-1:0]   ms_since_send;
    logic [MS_W-1:0]   ack_timeout;
    logic [TCNT_W-1:0] retry_limit;

    t_outbox_result expected_results [$];
    int fail_count = 0;

    // remove one entry and close the gap toward the head
    function automatic logic [TAG_W-1:0] take_entry(int pos);
        logic [TAG_W-1:0] tag;
        tag = box_tag[pos];
        for (int i = pos; i + 1 < box_count; i++) begin
            box_tag[i]   = box_tag[i + 1];
            box_mouse[i] = box_mouse[i + 1];
            box_crit[i]  = box_crit[i + 1];
        end
        box_count--;
        return tag;
    endfunction

    function automatic void add_entry(logic [TAG_W-1:0] tag, logic mouse, logic crit);
        box_tag[box_count]   = tag;
        box_mouse[box_count] = mouse;
        box_crit[box_count]  = crit;
        box_count++;
    endfunction

    // eviction preference on a full outbox, QUEUE_DEPTH means drop the newcomer
    function automatic int choose_victim(logic crit_new);
        int first;
        first = (head_in_flight && box_count > 0) ? 1 : 0;
        for (int i = first; i < box_count; i++)
            if (box_mouse[i] && !box_crit[i])
                return i;
        for (int i = box_count; i > first; i--)
            if (!box_crit[i - 1])
                return i - 1;
        if (first == 0 && box_count > 0)
            return 0;
        if (crit_new && first < box_count)
            return first;
        return QUEUE_DEPTH;
    endfunction

    // advance the shadow outbox by one request and form its result
    function automatic t_outbox_result predict_outbox_step(t_func fn, logic [TAG_W-1:0] tag,
                                                           logic mouse, logic coal, logic crit);
        t_outbox_result r;
        int victim;
        r = '0;
        r.status = ST_IGNORED;
        case (fn)
            FN_ENQUEUE: begin
                if (mouse && coal && box_count > 0 && box_mouse[box_count - 1]) begin
                    box_tag[box_count - 1] = tag;
                    r.status = ST_COALESCED;
                end else if (box_count >= QUEUE_DEPTH) begin
                    victim = choose_victim(crit);
                    if (victim < box_count) begin
                        r.ev_tag   = take_entry(victim);
                        r.ev_valid = 1'b1;
                        add_entry(tag, mouse, crit);
                        r.status = ST_EVICT_APPEND;
                    end else begin
                        r.status = ST_DROPPED;
                    end
                end else begin
                    add_entry(tag, mouse, crit);
                    r.status = ST_APPENDED;
                end
            end
            FN_ACK: begin
                if (head_in_flight) begin
                    if (box_count > 0)
                        void'(take_entry(0));
                    head_in_flight = 1'b0;
                    timeouts_seen  = '0;
                    r.status = ST_ACK_POPPED;
                end
            end
            FN_SENT: begin
                if (box_count > 0 && !head_in_flight) begin
                    head_in_flight = 1'b1;
                    ms_since_send  = '0;
                    r.status = ST_MARKED_SENT;
                end
            end
            default: begin
                r.status = ST_TICK;
                if (head_in_flight) begin
                    if (ms_since_send >= ack_timeout) begin
                        head_in_flight = 1'b0;
                        timeouts_seen  = timeouts_seen + 1'b1;
                        if (timeouts_seen >= retry_limit) begin
                            if (box_count > 0) begin
                                r.ev_tag   = take_entry(0);
                                r.ev_valid = 1'b1;
                            end
                            timeouts_seen = '0;
                            r.status = ST_TIMEOUT_DROP;
                        end else begin
                            r.status = ST_TIMEOUT_RETRY;
                        end
                    end else if (ms_since_send != '1) begin
                        ms_since_send = ms_since_send + 1'b1;
                    end
                end
            end
        endcase
        r.front_valid     = (box_count > 0);
        r.front_tag       = (box_count > 0) ? box_tag[0] : '0;
        r.front_in_flight = head_in_flight;
        r.count           = CNT_W'(box_count);
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [TAG_W-1:0] got, logic [TAG_W-1:0] want);
        $display("%0t ns: %s mismatch, got %0h expected %0h", $time, what, got, want);
        fail_count++;
    endtask

    // watch both channels and the register port at every rising edge
    always @(posedge i_clk) begin
        t_outbox_result got;
        t_outbox_result want;
        if (!i_rst_n) begin
            for (int i = 0; i < QUEUE_DEPTH; i++) begin
                box_tag[i]   = '0;
                box_mouse[i] = 1'b0;
                box_crit[i]  = 1'b0;
            end
            box_count      = 0;
            head_in_flight = 1'b0;
            timeouts_seen  = '0;
            ms_since_send  = '0;
            ack_timeout    = ACK_TIMEOUT_RST;
            retry_limit    = RETRY_LIMIT_RST;
            expected_results.delete();
        end else begin
            // results leaving the block
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                got.status          = t_status'(i_m_axis_tuser);
                got.ev_valid        = i_m_axis_tdata[0];
                got.ev_tag          = i_m_axis_tdata[16:1];
                got.front_valid     = i_m_axis_tdata[17];
                got.front_tag       = i_m_axis_tdata[33:18];
                got.front_in_flight = i_m_axis_tdata[34];
                got.count           = i_m_axis_tdata[38:35];
                if (expected_results.size() == 0) begin
                    report_mismatch("unrequested result status", TAG_W'(got.status), '0);
                end else begin
                    want = expected_results[0];
                    expected_results.delete(0);
                    if (got.status !== want.status)
                        report_mismatch("status", TAG_W'(got.status), TAG_W'(want.status));
                    if (got.ev_valid !== want.ev_valid)
                        report_mismatch("evicted_valid", TAG_W'(got.ev_valid),
                                        TAG_W'(want.ev_valid));
                    if (got.ev_tag !== want.ev_tag)
                        report_mismatch("evicted_tag", got.ev_tag, want.ev_tag);
                    if (got.front_valid !== want.front_valid)
                        report_mismatch("front_valid", TAG_W'(got.front_valid),
                                        TAG_W'(want.front_valid));
                    if (got.front_tag !== want.front_tag)
                        report_mismatch("front_tag", got.front_tag, want.front_tag);
                    if (got.front_in_flight !== want.front_in_flight)
                        report_mismatch("front_in_flight", TAG_W'(got.front_in_flight),
                                        TAG_W'(want.front_in_flight));
                    if (got.count !== want.count)
                        report_mismatch("entry_count", TAG_W'(got.count), TAG_W'(want.count));
                end
            end
            // register writes
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_ACK_TIMEOUT: ack_timeout = i_cfg_data;
                    CFG_RETRY_LIMIT: retry_limit = i_cfg_data[TCNT_W-1:0];
                    default: ;
                endcase
            end
            // requests entering the block
            if (i_s_axis_tvalid && i_s_axis_tready)
                expected_results.insert(expected_results.size(),
                    predict_outbox_step(t_func'(i_s_axis_tuser),
                    i_s_axis_tdata[15:0], i_s_axis_tdata[16], i_s_axis_tdata[17],
                    i_s_axis_tdata[18]));
        end
        o_fail_count = fail_count;
        o_pending    = expected_results.size();
    end

endmodule

@@ sim/tb_top.sv @@
module tb_top;
    import pdoq_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic                 clk      = 1'b0;
    logic                 rst_n    = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [23:0]          s_tdata  = '0;
    logic [1:0]           s_tuser  = FN_ENQUEUE;
    logic                 m_tvalid;
    logic                 m_tready = 1'b1;
    logic [39:0]          m_tdata;
    logic [3:0]           m_tuser;
    logic                 cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx  = CFG_ACK_TIMEOUT;
    logic [CFG_W-1:0]     cfg_data = '0;
    bit                   calm     = 1'b0;
    int                   fail_total;
    int                   results_pending;

    priority_drop_outbox_queue uut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data)
    );

    outbox_checker u_check (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .i_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .i_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .i_m_axis_tdata  (m_tdata),
        .i_m_axis_tuser  (m_tuser),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data),
        .o_fail_count    (fail_total),
        .o_pending       (results_pending)
    );

    always #4 clk = ~clk;

    // receiver stalls now and then unless in a calm stretch
    always @(negedge clk) begin
        m_tready <= calm || ($urandom_range(99) >= 6);
    end

    // offer one request, with random gaps before it, and wait for the handshake
    task automatic send_request(t_func fn, logic [15:0] tag, logic mouse, logic coal,
                                logic crit);
        while (!calm && $urandom_range(99) < 6) begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= fn;
        s_tdata  <= {5'b0, crit, coal, mouse, tag};
        do @(posedge clk); while (!s_tready);
        @(negedge clk);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (results_pending != 0)
            @(negedge clk);
    endtask

    // random request; profile 0 fills, 1 drains, 2 works the ack timeout
    task automatic send_random(int profile);
        int pick;
        t_func fn;
        logic [15:0] tag;
        pick = $urandom_range(99);
        case (profile)
            0:       fn = (pick < 70) ? FN_ENQUEUE : (pick < 80) ? FN_SENT :
                          (pick < 90) ? FN_TICK : FN_ACK;
            1:       fn = (pick < 25) ? FN_ENQUEUE : (pick < 50) ? FN_SENT :
                          (pick < 75) ? FN_ACK : FN_TICK;
            default: fn = (pick < 15) ? FN_ENQUEUE : (pick < 40) ? FN_SENT :
                          (pick < 45) ? FN_ACK : FN_TICK;
        endcase
        pick = $urandom_range(99);
        tag = (pick < 5) ? 16'h0000 : (pick < 10) ? 16'hFFFF : 16'($urandom_range(65535));
        send_request(fn, tag, 1'($urandom_range(1)), $urandom_range(99) < 60,
                     $urandom_range(99) < 30);
    endtask

    // one register setting, then bursts of random requests
    task automatic run_phase(logic [15:0] timeout, logic [3:0] limit, int n_items,
                             bit quiet);
        int done;
        int profile;
        int burst;
        wait_drained();
        write_register(CFG_ACK_TIMEOUT, timeout);
        write_register(CFG_RETRY_LIMIT, CFG_W'(limit));
        cfg_we <= 1'b0;
        calm = quiet;
        done = 0;
        while (done < n_items) begin
            profile = $urandom_range(2);
            burst   = $urandom_range(24, 8);
            repeat (burst) begin
                send_random(profile);
                done++;
            end
        end
        calm = 1'b0;
    endtask

    // overall run limit
    initial begin
        #3_000_000;
        $display("FAILURE");
        $finish;
    end

    initial begin
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // idle-state corner cases on the empty outbox
        send_request(FN_ACK,  16'h0000, 1'b0, 1'b0, 1'b0);
        send_request(FN_SENT, 16'h0000, 1'b0, 1'b0, 1'b0);
        send_request(FN_TICK, 16'h0000, 1'b0, 1'b0, 1'b0);
        // fill with protected entries, tag extremes at both ends
        for (int i = 0; i < QUEUE_DEPTH; i++)
            send_request(FN_ENQUEUE, (i == 0) ? 16'h0000 :
                         (i == QUEUE_DEPTH - 1) ? 16'hFFFF : 16'(16'h1000 + i),
                         i[0], 1'b0, 1'b1);
        // locked head and nothing evictable: plain newcomer dropped
        send_request(FN_SENT,    16'h0000, 1'b0, 1'b0, 1'b0);
        send_request(FN_ENQUEUE, 16'h2222, 1'b0, 1'b0, 1'b0);
        // critical newcomer pushes out the oldest entry behind the head
        send_request(FN_ENQUEUE, 16'h3333, 1'b0, 1'b0, 1'b1);
        send_request(FN_ACK,     16'h0000, 1'b0, 1'b0, 1'b0);
        // newest unprotected entry goes first
        send_request(FN_ENQUEUE, 16'h4444, 1'b0, 1'b0, 1'b0);
        send_request(FN_ENQUEUE, 16'h5555, 1'b1, 1'b1, 1'b1);
        // mouse update folds into the mouse tail
        send_request(FN_ENQUEUE, 16'h6666, 1'b1, 1'b1, 1'b0);
        // all protected and head unlocked: head is evicted
        send_request(FN_ENQUEUE, 16'h7777, 1'b1, 1'b0, 1'b0);
        // oldest unprotected mouse entry goes first
        send_request(FN_ENQUEUE, 16'h8888, 1'b0, 1'b1, 1'b1);
        // send twice, tick, ack
        send_request(FN_SENT,    16'h0000, 1'b0, 1'b0, 1'b0);
        send_request(FN_SENT,    16'h0000, 1'b0, 1'b0, 1'b0);
        send_request(FN_TICK,    16'h0000, 1'b0, 1'b0, 1'b0);
        send_request(FN_ACK,     16'h0000, 1'b0, 1'b0, 1'b0);

        // random traffic over several register settings
        run_phase(16'd120,   4'd2,  120, 1'b0);
        run_phase(16'd1,     4'd1,  110, 1'b0);
        run_phase(16'd0,     4'd0,  100, 1'b1);
        run_phase(16'd3,     4'd15, 140, 1'b0);
        run_phase(16'hFFFF,  4'd15, 100, 1'b0);
        run_phase(16'd2,     4'd3,  120, 1'b0);
        run_phase(16'd1,     4'd4,  110, 1'b0);
        run_phase(16'd4,     4'd2,   60, 1'b0);

        wait_drained();
        repeat (3) @(posedge clk);
        if (fail_total == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
